// ----- hdl/rx_buffer_idle_gap_framer_assert.svh -----
// ----------------------------------------------------------------------------
// rx buffer idle gap framer assertion macros
// clocked concurrent assertions, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef RX_BUFFER_IDLE_GAP_FRAMER_ASSERT_SVH
`define RX_BUFFER_IDLE_GAP_FRAMER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define RXB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// overlapping implication, antecedent and consequent given apart
`define RXB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rxb_pkg.sv -----
// ----------------------------------------------------------------------------
// rxb_pkg
// types and constants shared by the rx buffer idle gap framer
// ----------------------------------------------------------------------------
package rxb_pkg;

  // default store depth
  localparam int unsigned BUF_DEPTH = 256;

  // gap limit after reset
  localparam logic [7:0] GAP_LIMIT_RESET = 8'd2;

  // item commands
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_ARM  = 2'd2,
    CMD_READ = 2'd3
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  // input item
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_data;
    logic       line_error;
    logic       long_answer;
    logic       need_answer;
    logic [7:0] read_index;
  } item_t;

  // result item
  typedef struct packed {
    logic [7:0] read_data;
    logic [8:0] fill_count;
    logic       wrapped;
    logic       message_ready;
    logic       waiting;
  } result_t;

  // write request from the sequencer to the store
  typedef struct packed {
    logic       we;
    logic [7:0] wdata;
  } wr_ctl_t;

endpackage

// ----- hdl/rxb_store.sv -----
// ----------------------------------------------------------------------------
// rxb_store
// byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module rxb_store #(
  parameter int unsigned Depth = rxb_pkg::BUF_DEPTH,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  rxb_pkg::wr_ctl_t    wr_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr_i] <= wr_i.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rxb_ctrl.sv -----
// ----------------------------------------------------------------------------
// rxb_ctrl
// command sequencer: fill position, gap timer, framing flags and store access
// ----------------------------------------------------------------------------
module rxb_ctrl #(
  parameter int unsigned BufDepth = rxb_pkg::BUF_DEPTH,
  localparam int unsigned AddrW = $clog2(BufDepth),
  localparam int unsigned PosW  = $clog2(BufDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rxb_pkg::item_t      item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  output rxb_pkg::wr_ctl_t    wr_o,
  output logic [AddrW-1:0]    waddr_o,
  output logic                re_o,
  output logic [AddrW-1:0]    raddr_o,
  input  logic [7:0]          rdata_i,
  output logic                done_o,
  output rxb_pkg::result_t    result_o
);

  rxb_pkg::state_e state_q, state_d;
  rxb_pkg::item_t  item_q;

  logic [7:0]      gap_limit_q;
  logic [PosW-1:0] wpos_q, wpos_d;
  logic [7:0]      gap_q, gap_d;
  logic            timer_q, timer_d;
  logic            wait_q, wait_d;
  logic            ready_q, ready_d;
  logic            long_q, long_d;
  logic            wrap_q, wrap_d;
  logic            warm_q, warm_d;    // store fully written since last arm
  logic            rd_ok_q, rd_ok_d;  // read entry holds written data

  logic [7:0]      gap_inc;
  logic            full;
  logic            in_range;
  logic            below_fill;

  assign cfg_ready_o = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= rxb_pkg::GAP_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gap_limit_q <= cfg_data_i;
    end
  end

  // capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rxb_pkg::ST_IDLE: begin
        if (start) state_d = rxb_pkg::ST_EXEC;
      end
      rxb_pkg::ST_EXEC: state_d = rxb_pkg::ST_RESP;
      rxb_pkg::ST_RESP: state_d = rxb_pkg::ST_IDLE;
      default:          state_d = rxb_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy   = (state_q != rxb_pkg::ST_IDLE);
    done_o = (state_q == rxb_pkg::ST_RESP);
  end

  assign gap_inc    = gap_q + 8'd1;
  assign full       = (wpos_q == PosW'(BufDepth));
  assign in_range   = (32'(item_q.read_index) < 32'(BufDepth));
  assign below_fill = (32'(item_q.read_index) < 32'(wpos_q));

  // command execution and store access
  always_comb begin
    wpos_d   = wpos_q;
    gap_d    = gap_q;
    timer_d  = timer_q;
    wait_d   = wait_q;
    ready_d  = ready_q;
    long_d   = long_q;
    wrap_d   = wrap_q;
    warm_d   = warm_q;
    rd_ok_d  = rd_ok_q;
    wr_o.we    = 1'b0;
    wr_o.wdata = item_q.rx_data;
    waddr_o  = AddrW'(wpos_q);
    re_o     = 1'b0;
    raddr_o  = AddrW'(item_q.read_index);
    if (state_q == rxb_pkg::ST_EXEC) begin
      rd_ok_d = 1'b0;
      case (item_q.cmd)
        rxb_pkg::CMD_BYTE: begin
          if (item_q.line_error) begin
            gap_d = 8'd0;
          end else if (!full) begin
            wr_o.we = 1'b1;
            wpos_d  = PosW'(wpos_q + PosW'(1));
            timer_d = 1'b1;
            gap_d   = 8'd0;
          end else if (long_q) begin
            // wrap around to the first entry
            wr_o.we = 1'b1;
            waddr_o = '0;
            wpos_d  = PosW'(1);
            wrap_d  = 1'b1;
            warm_d  = 1'b1;
            timer_d = 1'b1;
            gap_d   = 8'd0;
          end
        end
        rxb_pkg::CMD_TICK: begin
          if (timer_q && wait_q) begin
            gap_d = gap_inc;
            if (gap_inc > gap_limit_q) begin
              wait_d  = 1'b0;
              ready_d = 1'b1;
              long_d  = 1'b0;
              timer_d = 1'b0;
            end
          end
        end
        rxb_pkg::CMD_ARM: begin
          // entries at or above the fill position read as zero until the store wraps
          wpos_d  = '0;
          gap_d   = 8'd0;
          ready_d = 1'b0;
          long_d  = item_q.long_answer;
          wait_d  = item_q.need_answer;
          warm_d  = 1'b0;
        end
        rxb_pkg::CMD_READ: begin
          re_o    = 1'b1;
          rd_ok_d = in_range && (warm_q || below_fill);
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rxb_pkg::ST_IDLE;
      wpos_q  <= '0;
      gap_q   <= 8'd0;
      timer_q <= 1'b0;
      wait_q  <= 1'b0;
      ready_q <= 1'b0;
      long_q  <= 1'b0;
      wrap_q  <= 1'b0;
      warm_q  <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wpos_q  <= wpos_d;
      gap_q   <= gap_d;
      timer_q <= timer_d;
      wait_q  <= wait_d;
      ready_q <= ready_d;
      long_q  <= long_d;
      wrap_q  <= wrap_d;
      warm_q  <= warm_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // result beat
  always_comb begin
    result_o.read_data     = rd_ok_q ? rdata_i : 8'd0;
    result_o.fill_count    = 9'(wpos_q);
    result_o.wrapped       = wrap_q;
    result_o.message_ready = ready_q;
    result_o.waiting       = wait_q;
  end

endmodule

// ----- hdl/rx_buffer_idle_gap_framer.sv -----
// ----------------------------------------------------------------------------
// rx_buffer_idle_gap_framer
// receive buffer that frames a modem answer by an idle gap on the line
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer
//  ---------+----------------------------------+----------------------------
//  item     | start, busy, item_i              | start && !busy
//  result   | done_o, result_o                 | done_o, held one cycle
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i && cfg_ready_o
//
//  every command passes the same states from accept to the next accept:
//  idle to capture, exec for the store access, resp with done_o high; the
//  registered store read port sets this. arm takes the same path: stale
//  entries at or above the fill position read as zero, so no clearing pass.
//  reset is asynchronous and clears the control state, not the store.
//  the receiver cannot stall; config is always ready.
// ----------------------------------------------------------------------------
module rx_buffer_idle_gap_framer #(
  parameter int unsigned BufDepth = rxb_pkg::BUF_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rxb_pkg::item_t   item_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i,
  output logic             done_o,
  output rxb_pkg::result_t result_o
);

  localparam int unsigned AddrW = $clog2(BufDepth);

  rxb_pkg::wr_ctl_t  wr;
  logic [AddrW-1:0]  waddr;
  logic              re;
  logic [AddrW-1:0]  raddr;
  logic [7:0]        rdata;

  // sequencer
  rxb_ctrl #(
    .BufDepth(BufDepth)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .wr_o     (wr),
    .waddr_o  (waddr),
    .re_o     (re),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .done_o,
    .result_o
  );

  // byte store
  rxb_store #(
    .Depth(BufDepth)
  ) u_store (
    .clk_i,
    .wr_i    (wr),
    .waddr_i (waddr),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ----- hdl/rxb_checker.sv -----
// ----------------------------------------------------------------------------
// rxb_checker
// port-level assertions for the rx buffer idle gap framer, bound to the top
// ----------------------------------------------------------------------------
`include "rx_buffer_idle_gap_framer_assert.svh"

module rxb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input rxb_pkg::item_t   item_i,
  input logic             done_o,
  input rxb_pkg::result_t result_o
);

  logic accept;
  logic is_read;
  logic rd_zero;

  assign accept  = start && !busy;
  assign is_read = (item_i.cmd == rxb_pkg::CMD_READ);
  assign rd_zero = (result_o.read_data == 8'd0);

  // an accepted beat makes the block busy
  `RXB_ASSERT(a_accept_busy, accept |=> busy, "accepted beat did not raise busy")

  // the result strobe comes after accept, once the exec state has passed
  `RXB_ASSERT_IMP(a_result_lat, accept, ##2 done_o, "result strobe missing")

  // a result only appears while busy
  `RXB_ASSERT_IMP(a_done_busy, done_o, busy, "result strobe while idle")

  // one strobe per beat
  `RXB_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held twice")

  // only reads return store data
  `RXB_ASSERT_IMP(a_read_zero, done_o && !$past(is_read, 2), rd_zero, "read data on non-read")

endmodule

bind rx_buffer_idle_gap_framer rxb_checker u_rxb_checker (.*);
